>>> src/tvs_pkg.sv
`timescale 1ns / 1ps
// tvs_pkg: shared types, widths and constants for the triangle vertex setup block
// used by tvs_mul, tvs_ctrl and triangle_vertex_setup_winding_fix; no dependencies

package tvs_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // triangle check widths: edge deltas, normal sums, cross and dot accumulators
  localparam int DIFF_W = 33;
  localparam int NSUM_W = 18;
  localparam int CROSS_W = PROD_W;
  localparam int DOT_W  = 88;
  localparam int HI_SHIFT = 33;

  // sequencer counter
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] SCALE_LAST = 4'd3;
  localparam logic [CNT_W-1:0] CHECK_LAST = 4'd11;
  localparam logic [CNT_W-1:0] EMIT_LAST  = 4'd2;
  localparam logic [1:0]       EMIT_LAST_K = 2'd2;
  localparam logic [1:0]       SLOT_LAST  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_U    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_V    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_ALL  = 3'd5;

  // fixed-point constants
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  // check step kinds within one cross/dot component
  localparam logic [1:0] STEP_PROD_A = 2'd0;
  localparam logic [1:0] STEP_PROD_B = 2'd1;
  localparam logic [1:0] STEP_DOT_LO = 2'd2;
  localparam logic [1:0] STEP_DOT_HI = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIFF,
    ST_CHK_MUL,
    ST_CHK_ACC,
    ST_EMIT
  } tvs_state_e;

  // multiplier operand source
  typedef enum logic [1:0] {
    MS_IN_X,
    MS_POS_Y,
    MS_POS_Z,
    MS_CHECK
  } tvs_msel_e;

  // status from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic slot_last;
    logic any_neg;
  } tvs_stat_t;

  // controls from sequencer to datapath
  typedef struct packed {
    logic             ready;
    logic             accept;
    tvs_msel_e        msel;
    logic             wb_en;
    logic [1:0]       wb_axis;
    logic             slot_adv;
    logic             diff_en;
    logic             acc_en;
    logic [CNT_W-1:0] op;
    logic             emit_en;
    logic [1:0]       emit_k;
  } tvs_ctrl_t;

  // floor-shifted product saturated to 32 bits
  function automatic logic signed [31:0] sat_q16(input logic signed [PROD_W-17:0] v);
    logic [PROD_W-48:0] hi;
    begin
      hi = v[PROD_W-17:31];
      if ((&hi) || !(|hi)) sat_q16 = v[31:0];
      else if (v[PROD_W-17]) sat_q16 = 32'sh8000_0000;
      else sat_q16 = 32'sh7fff_ffff;
    end
  endfunction

  // one minus a Q16.16 value, saturated
  function automatic logic signed [31:0] flip_q16(input logic signed [31:0] t);
    logic signed [32:0] d;
    begin
      d = 33'(ONE_Q16) - 33'(t);
      if (d[32] == d[31]) flip_q16 = d[31:0];
      else if (d[32]) flip_q16 = 32'sh8000_0000;
      else flip_q16 = 32'sh7fff_ffff;
    end
  endfunction

  // negation of a Q2.14 value, saturated
  function automatic logic signed [15:0] neg_q14(input logic signed [15:0] n);
    begin
      if (n == 16'sh8000) neg_q14 = 16'sh7fff;
      else neg_q14 = -n;
    end
  endfunction

endpackage

>>> src/triangle_vertex_setup_winding_fix.sv
`timescale 1ns / 1ps
// triangle_vertex_setup_winding_fix: top level with vertex stores, check datapath, output register
// depends on tvs_pkg, tvs_mul and tvs_ctrl
//
// for each vertex the shared multiplier scales x, y and z one after the other
// after the third vertex, when any scale is negative, the orientation check runs:
//   an edge-delta step and twelve multiply/accumulate pairs through the same multiplier
// the three results then leave one per cycle while out_stall_i stays low
// reset clears the sequencer, slot count and output valid and loads the default registers;
//   the vertex stores keep no reset value

module triangle_vertex_setup_winding_fix import tvs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  // vertex input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic signed [31:0]    pos_z_i,
  input  logic signed [31:0]    tex_u_i,
  input  logic signed [31:0]    tex_v_i,
  input  logic signed [15:0]    norm_x_i,
  input  logic signed [15:0]    norm_y_i,
  input  logic signed [15:0]    norm_z_i,
  // vertex output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    out_x_o,
  output logic signed [31:0]    out_y_o,
  output logic signed [31:0]    out_z_o,
  output logic signed [31:0]    out_u_o,
  output logic signed [31:0]    out_v_o,
  output logic signed [15:0]    out_nx_o,
  output logic signed [15:0]    out_ny_o,
  output logic signed [15:0]    out_nz_o,
  output logic                  last_of_triangle_o
);

  tvs_ctrl_t ctl;
  tvs_stat_t stat;

  logic signed [31:0] scale_q [3];
  logic               flip_u_q, flip_v_q, flip_all_q;
  logic [1:0]         slot_q;
  logic               any_neg;

  // vertex stores, indexed by slot then axis
  logic signed [31:0] pos_st_q [3][3];
  logic signed [31:0] tex_st_q [3][2];
  logic signed [15:0] nrm_st_q [3][3];

  // captured y and z positions of the vertex in flight
  logic signed [31:0] pos_y_q, pos_z_q;

  // check datapath
  logic signed [DIFF_W-1:0]  av_q [3];
  logic signed [DIFF_W-1:0]  bv_q [3];
  logic signed [NSUM_W-1:0]  nsum_q [3];
  logic signed [CROSS_W-1:0] c_q;
  logic signed [DOT_W-1:0]   d_q;
  logic signed [DOT_W-1:0]   p_ext;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [1:0]                comp, step, i1, i2;
  logic signed [NSUM_W-1:0]  nsel;
  logic                      d_pos, swap;
  logic [1:0]                src;

  // output register
  logic               out_valid_q, out_last_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q, out_u_q, out_v_q;
  logic signed [15:0] out_nx_q, out_ny_q, out_nz_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q[0] <= ONE_Q16;
      scale_q[1] <= ONE_Q16;
      scale_q[2] <= ONE_Q16;
      flip_u_q   <= 1'b0;
      flip_v_q   <= 1'b0;
      flip_all_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SCALE_X:  scale_q[0] <= cfg_data_i;
        CFG_SCALE_Y:  scale_q[1] <= cfg_data_i;
        CFG_SCALE_Z:  scale_q[2] <= cfg_data_i;
        CFG_FLIP_U:   flip_u_q   <= cfg_data_i[0];
        CFG_FLIP_V:   flip_v_q   <= cfg_data_i[0];
        CFG_FLIP_ALL: flip_all_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a vertex offered in the idle cycle goes first, so one vertex sees one register set
  assign cfg_ready_o = ctl.ready && !in_valid_i;
  assign any_neg     = scale_q[0][31] | scale_q[1][31] | scale_q[2][31];

  // sequencer
  assign stat.in_valid  = in_valid_i;
  assign stat.out_free  = !out_valid_q || !out_stall_i;
  assign stat.slot_last = (slot_q == SLOT_LAST);
  assign stat.any_neg   = any_neg;

  tvs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  assign in_stall_o = !ctl.ready;

  // slot count within the triangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (ctl.slot_adv) begin
      slot_q <= (slot_q == SLOT_LAST) ? 2'd0 : slot_q + 2'd1;
    end
  end

  // check operand selection: component and step from the op index
  assign comp = ctl.op[3:2];
  assign step = ctl.op[1:0];

  always_comb begin
    unique case (comp)
      2'd0: begin
        i1 = 2'd1; i2 = 2'd2; nsel = nsum_q[0];
      end
      2'd1: begin
        i1 = 2'd2; i2 = 2'd0; nsel = nsum_q[1];
      end
      default: begin
        i1 = 2'd0; i2 = 2'd1; nsel = nsum_q[2];
      end
    endcase
  end

  // multiplier operand mux
  always_comb begin
    unique case (ctl.msel)
      MS_IN_X: begin
        mul_a = MUL_W'(pos_x_i);
        mul_b = MUL_W'(scale_q[0]);
      end
      MS_POS_Y: begin
        mul_a = MUL_W'(pos_y_q);
        mul_b = MUL_W'(scale_q[1]);
      end
      MS_POS_Z: begin
        mul_a = MUL_W'(pos_z_q);
        mul_b = MUL_W'(scale_q[2]);
      end
      default: begin
        unique case (step)
          STEP_PROD_A: begin
            mul_a = MUL_W'(av_q[i1]);
            mul_b = MUL_W'(bv_q[i2]);
          end
          STEP_PROD_B: begin
            mul_a = MUL_W'(av_q[i2]);
            mul_b = MUL_W'(bv_q[i1]);
          end
          STEP_DOT_LO: begin
            mul_a = {1'b0, c_q[HI_SHIFT-1:0]};
            mul_b = MUL_W'(nsel);
          end
          default: begin
            mul_a = c_q[HI_SHIFT+MUL_W-1:HI_SHIFT];
            mul_b = MUL_W'(nsel);
          end
        endcase
      end
    endcase
  end

  tvs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign p_ext = DOT_W'(prod);

  // vertex capture, scaled position write back and check registers
  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
      tex_st_q[slot_q][0] <= flip_u_q ? flip_q16(tex_u_i) : tex_u_i;
      tex_st_q[slot_q][1] <= flip_v_q ? flip_q16(tex_v_i) : tex_v_i;
      nrm_st_q[slot_q][0] <= scale_q[0][31] ? neg_q14(norm_x_i) : norm_x_i;
      nrm_st_q[slot_q][1] <= scale_q[1][31] ? neg_q14(norm_y_i) : norm_y_i;
      nrm_st_q[slot_q][2] <= scale_q[2][31] ? neg_q14(norm_z_i) : norm_z_i;
    end
    if (ctl.wb_en) begin
      pos_st_q[slot_q][ctl.wb_axis] <= sat_q16(prod[PROD_W-1:16]);
    end
    // edge deltas and normal sums
    if (ctl.diff_en) begin
      for (int i = 0; i < 3; i++) begin
        av_q[i]   <= DIFF_W'(pos_st_q[1][i]) - DIFF_W'(pos_st_q[0][i]);
        bv_q[i]   <= DIFF_W'(pos_st_q[2][i]) - DIFF_W'(pos_st_q[0][i]);
        nsum_q[i] <= NSUM_W'(nrm_st_q[0][i]) + NSUM_W'(nrm_st_q[1][i])
                   + NSUM_W'(nrm_st_q[2][i]);
      end
      d_q <= '0;
    end
    // cross and dot accumulation
    if (ctl.acc_en) begin
      unique case (step)
        STEP_PROD_A: c_q <= prod;
        STEP_PROD_B: c_q <= c_q - prod;
        STEP_DOT_LO: d_q <= d_q + p_ext;
        default:     d_q <= d_q + (p_ext <<< HI_SHIFT);
      endcase
    end
  end

  // winding decision and output slot order
  assign d_pos = !d_q[DOT_W-1] && (|d_q);
  assign swap  = (any_neg && !d_pos) ^ flip_all_q;

  always_comb begin
    unique case (ctl.emit_k)
      2'd0:    src = swap ? 2'd2 : 2'd0;
      2'd2:    src = swap ? 2'd0 : 2'd2;
      default: src = 2'd1;
    endcase
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (ctl.emit_en) begin
      out_x_q    <= pos_st_q[src][0];
      out_y_q    <= pos_st_q[src][1];
      out_z_q    <= pos_st_q[src][2];
      out_u_q    <= tex_st_q[src][0];
      out_v_q    <= tex_st_q[src][1];
      out_nx_q   <= nrm_st_q[src][0];
      out_ny_q   <= nrm_st_q[src][1];
      out_nz_q   <= nrm_st_q[src][2];
      out_last_q <= (ctl.emit_k == EMIT_LAST_K);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_x_o            = out_x_q;
  assign out_y_o            = out_y_q;
  assign out_z_o            = out_z_q;
  assign out_u_o            = out_u_q;
  assign out_v_o            = out_v_q;
  assign out_nx_o           = out_nx_q;
  assign out_ny_o           = out_ny_q;
  assign out_nz_o           = out_nz_q;
  assign last_of_triangle_o = out_last_q;

  // a new result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit_en |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending transfer");

  // slot count stays within one triangle
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q != 2'd3)
    else $error("slot count out of range");

  // third result of a triangle carries the last marker
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.emit_en && ctl.emit_k == EMIT_LAST_K) |=> (out_valid_q && out_last_q))
    else $error("last result not marked");

  // orientation check only runs with a negative scale
  a_check_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.diff_en |-> any_neg)
    else $error("orientation check without negative scale");

endmodule

>>> src/tvs_mul.sv
`timescale 1ns / 1ps
// tvs_mul: shared signed multiplier with registered product
// depends on tvs_pkg for operand and product widths

module tvs_mul import tvs_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> src/tvs_ctrl.sv
`timescale 1ns / 1ps
// tvs_ctrl: sequencer for vertex scaling, orientation check and triangle output
// depends on tvs_pkg for state, status and control types

module tvs_ctrl import tvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tvs_stat_t stat_i,
  output tvs_ctrl_t ctl_o
);

  tvs_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = ST_SCALE;
          cnt_d   = CNT_W'(1);
        end
      end
      ST_SCALE: begin
        if (cnt_q == SCALE_LAST) begin
          cnt_d = '0;
          if (!stat_i.slot_last) state_d = ST_IDLE;
          else if (stat_i.any_neg) state_d = ST_DIFF;
          else state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIFF: begin
        state_d = ST_CHK_MUL;
        cnt_d   = '0;
      end
      ST_CHK_MUL: begin
        state_d = ST_CHK_ACC;
      end
      ST_CHK_ACC: begin
        if (cnt_q == CHECK_LAST) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end else begin
          state_d = ST_CHK_MUL;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          if (cnt_q == EMIT_LAST) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // control outputs
  always_comb begin
    ctl_o          = '0;
    ctl_o.msel     = MS_IN_X;
    ctl_o.op       = cnt_q;
    ctl_o.emit_k   = cnt_q[1:0];
    ctl_o.wb_axis  = cnt_q[1:0] - 2'd1;
    unique case (state_q)
      ST_IDLE: begin
        ctl_o.ready  = 1'b1;
        ctl_o.accept = stat_i.in_valid;
      end
      ST_SCALE: begin
        ctl_o.wb_en    = 1'b1;
        ctl_o.msel     = (cnt_q == CNT_W'(1)) ? MS_POS_Y : MS_POS_Z;
        ctl_o.slot_adv = (cnt_q == SCALE_LAST);
      end
      ST_DIFF: begin
        ctl_o.diff_en = 1'b1;
      end
      ST_CHK_MUL: begin
        ctl_o.msel = MS_CHECK;
      end
      ST_CHK_ACC: begin
        ctl_o.acc_en = 1'b1;
      end
      ST_EMIT: begin
        ctl_o.emit_en = stat_i.out_free;
      end
      default: begin
        ctl_o.ready = 1'b0;
      end
    endcase
  end

endmodule

>>> dv/triangle_vertex_setup_winding_fix_tb.sv
`timescale 1ns / 1ps
// triangle_vertex_setup_winding_fix_tb: self-checking bench for the triangle vertex setup block
// depends on tvs_pkg and triangle_vertex_setup_winding_fix; a scoreboard class predicts the
// emitted vertex order and values, plain tasks drive the vertex and register channels

import tvs_pkg::*;

// one vertex as it enters or leaves the block; last is only meaningful on output
typedef struct packed {
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic signed [31:0] u;
  logic signed [31:0] v;
  logic signed [15:0] nx;
  logic signed [15:0] ny;
  logic signed [15:0] nz;
  logic               last;
} vertex_t;

class tri_setup_scoreboard;
  logic signed [31:0] scale [3];
  bit                 flip_u;
  bit                 flip_v;
  bit                 flip_all;
  vertex_t            slot_vtx [3];
  int unsigned        slot;
  vertex_t            ordered_q [$];
  int unsigned        n_errors;
  int unsigned        n_checked;
  int unsigned        n_triangles;
  int unsigned        n_reordered;

  function new();
    scale[0] = ONE_Q16;
    scale[1] = ONE_Q16;
    scale[2] = ONE_Q16;
    flip_u = 1'b0;
    flip_v = 1'b0;
    flip_all = 1'b0;
    slot = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    unique case (idx)
      CFG_SCALE_X: scale[0] = data;
      CFG_SCALE_Y: scale[1] = data;
      CFG_SCALE_Z: scale[2] = data;
      CFG_FLIP_U:  flip_u = data[0];
      CFG_FLIP_V:  flip_v = data[0];
      CFG_FLIP_ALL: flip_all = data[0];
      default: ;
    endcase
  endfunction

  function logic signed [31:0] sat32(longint val);
    if (val > 64'sd2147483647) return 32'sh7fff_ffff;
    if (val < -64'sd2147483648) return 32'sh8000_0000;
    return val[31:0];
  endfunction

  // product floored to Q16.16, then saturated
  function logic signed [31:0] scale_axis(logic signed [31:0] p, logic signed [31:0] s);
    longint prod;
    prod = longint'(p) * longint'(s);
    return sat32(prod >>> 16);
  endfunction

  function logic signed [31:0] one_minus(logic signed [31:0] t);
    return sat32(longint'(ONE_Q16) - longint'(t));
  endfunction

  // negate on a mirrored axis, most negative value clamps to most positive
  function logic signed [15:0] fix_normal(logic signed [15:0] n, logic signed [31:0] s);
    if (!s[31]) return n;
    if (n == 16'sh8000) return 16'sh7fff;
    return -n;
  endfunction

  function void take_vertex(vertex_t vi);
    vertex_t             pv;
    logic signed [127:0] ax, ay, az, bx, by, bz;
    logic signed [127:0] cx, cy, cz, sx, sy, sz, dot;
    int                  order [3];
    int                  t;
    bit                  any_neg;
    pv.x = scale_axis(vi.x, scale[0]);
    pv.y = scale_axis(vi.y, scale[1]);
    pv.z = scale_axis(vi.z, scale[2]);
    pv.u = flip_u ? one_minus(vi.u) : vi.u;
    pv.v = flip_v ? one_minus(vi.v) : vi.v;
    pv.nx = fix_normal(vi.nx, scale[0]);
    pv.ny = fix_normal(vi.ny, scale[1]);
    pv.nz = fix_normal(vi.nz, scale[2]);
    pv.last = 1'b0;
    slot_vtx[slot] = pv;
    if (slot < 2) begin
      slot++;
      return;
    end
    slot = 0;
    n_triangles++;

    // exact edge cross product against the summed normals
    ax = slot_vtx[1].x - slot_vtx[0].x;
    ay = slot_vtx[1].y - slot_vtx[0].y;
    az = slot_vtx[1].z - slot_vtx[0].z;
    bx = slot_vtx[2].x - slot_vtx[0].x;
    by = slot_vtx[2].y - slot_vtx[0].y;
    bz = slot_vtx[2].z - slot_vtx[0].z;
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    sx = slot_vtx[0].nx + slot_vtx[1].nx + slot_vtx[2].nx;
    sy = slot_vtx[0].ny + slot_vtx[1].ny + slot_vtx[2].ny;
    sz = slot_vtx[0].nz + slot_vtx[1].nz + slot_vtx[2].nz;
    dot = cx * sx + cy * sy + cz * sz;

    // winding fix, then the global flip on top
    order = '{0, 1, 2};
    any_neg = scale[0][31] || scale[1][31] || scale[2][31];
    if (any_neg && !(dot > 0)) begin
      order[0] = 2;
      order[2] = 0;
    end
    if (flip_all) begin
      t = order[0];
      order[0] = order[2];
      order[2] = t;
    end
    if (order[0] == 2) n_reordered++;
    for (int k = 0; k < 3; k++) begin
      pv = slot_vtx[order[k]];
      pv.last = (k == 2);
      ordered_q.push_back(pv);
    end
  endfunction

  function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  function void check_vertex(vertex_t got);
    vertex_t want;
    if (ordered_q.size() == 0) begin
      $display("%0t: unexpected vertex, expected none, actual x=%h y=%h z=%h last=%b",
               $time, got.x, got.y, got.z, got.last);
      n_errors++;
      return;
    end
    want = ordered_q.pop_front();
    n_checked++;
    cmp_field("out_x", want.x, got.x);
    cmp_field("out_y", want.y, got.y);
    cmp_field("out_z", want.z, got.z);
    cmp_field("out_u", want.u, got.u);
    cmp_field("out_v", want.v, got.v);
    cmp_field("out_nx", want.nx, got.nx);
    cmp_field("out_ny", want.ny, got.ny);
    cmp_field("out_nz", want.nz, got.nz);
    cmp_field("last_of_triangle", want.last, got.last);
  endfunction

  function int unsigned pending();
    return ordered_q.size();
  endfunction
endclass

module triangle_vertex_setup_winding_fix_tb;

  localparam int          TOTAL_VERTICES = 250;
  localparam int          SETTLE_CYCLES  = 48;
  localparam int          HOLD_AT        = 90;
  localparam int          HOLD_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [15:0] N_MAX = 16'sh7fff;
  localparam logic signed [15:0] N_MIN = 16'sh8000;
  localparam logic signed [15:0] N_UP  = 16'sh4000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [31:0]   pos_x_i = '0;
  logic signed [31:0]   pos_y_i = '0;
  logic signed [31:0]   pos_z_i = '0;
  logic signed [31:0]   tex_u_i = '0;
  logic signed [31:0]   tex_v_i = '0;
  logic signed [15:0]   norm_x_i = '0;
  logic signed [15:0]   norm_y_i = '0;
  logic signed [15:0]   norm_z_i = '0;
  logic                 out_valid_o;
  wire                  out_stall_i;
  logic signed [31:0]   out_x_o;
  logic signed [31:0]   out_y_o;
  logic signed [31:0]   out_z_o;
  logic signed [31:0]   out_u_o;
  logic signed [31:0]   out_v_o;
  logic signed [15:0]   out_nx_o;
  logic signed [15:0]   out_ny_o;
  logic signed [15:0]   out_nz_o;
  logic                 last_of_triangle_o;

  logic        rx_gap = 1'b0;
  logic        rx_hold = 1'b0;
  bit          quiet = 1'b0;
  int          rx_left = 0;
  int          vertices_sent = 0;
  int          settings_applied = 0;
  int unsigned cycle_count = 0;

  tri_setup_scoreboard sb = new();

  assign out_stall_i = rx_gap | rx_hold;

  triangle_vertex_setup_winding_fix u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .pos_z_i            (pos_z_i),
    .tex_u_i            (tex_u_i),
    .tex_v_i            (tex_v_i),
    .norm_x_i           (norm_x_i),
    .norm_y_i           (norm_y_i),
    .norm_z_i           (norm_z_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_x_o            (out_x_o),
    .out_y_o            (out_y_o),
    .out_z_o            (out_z_o),
    .out_u_o            (out_u_o),
    .out_v_o            (out_v_o),
    .out_nx_o           (out_nx_o),
    .out_ny_o           (out_ny_o),
    .out_nz_o           (out_nz_o),
    .last_of_triangle_o (last_of_triangle_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d vertices still expected", $time, sb.pending());
      $display("triangle_vertex_setup_winding_fix_tb: errors");
      $finish;
    end
  end

  // output side: check each transfer, then draw a stall gap
  always @(posedge clk_i) begin : rx_side
    vertex_t got;
    if (out_valid_o && !out_stall_i) begin
      got.x = out_x_o;
      got.y = out_y_o;
      got.z = out_z_o;
      got.u = out_u_o;
      got.v = out_v_o;
      got.nx = out_nx_o;
      got.ny = out_ny_o;
      got.nz = out_nz_o;
      got.last = last_of_triangle_o;
      sb.check_vertex(got);
      rx_left = quiet ? 0 : $urandom_range(0, 3);
    end else if (rx_left > 0 && rx_gap) begin
      rx_left--;
    end
    rx_gap <= (rx_left > 0);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (vertices_sent >= HOLD_AT);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  function automatic vertex_t vtx(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z, logic signed [31:0] u,
                                  logic signed [31:0] v, logic signed [15:0] nx,
                                  logic signed [15:0] ny, logic signed [15:0] nz);
    vertex_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.u = u;
    r.v = v;
    r.nx = nx;
    r.ny = ny;
    r.nz = nz;
    r.last = 1'b0;
    return r;
  endfunction

  // mix of extremes, small values near the origin and full-range values
  function automatic logic signed [31:0] rand_coord();
    unique case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return ($urandom_range(0, 1) != 0) ? ONE_Q16 : -ONE_Q16;
      3, 4: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_normal();
    unique case ($urandom_range(0, 9))
      0: return N_MIN;
      1: return N_MAX;
      2: return N_UP;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_scale();
    unique case ($urandom_range(0, 7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return ONE_Q16;
      4: return -ONE_Q16;
      5, 6: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  // random vertex; now and then it repeats the previous position for a flat triangle
  function automatic vertex_t rand_vertex(vertex_t prev);
    vertex_t r;
    r = vtx(rand_coord(), rand_coord(), rand_coord(), $urandom, $urandom,
            rand_normal(), rand_normal(), rand_normal());
    if ($urandom_range(0, 9) == 0) begin
      r.x = prev.x;
      r.y = prev.y;
      r.z = prev.z;
    end
    return r;
  endfunction

  // one vertex transfer after a random gap
  task automatic send_vertex(vertex_t vi);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= vi.x;
    pos_y_i <= vi.y;
    pos_z_i <= vi.z;
    tex_u_i <= vi.u;
    tex_v_i <= vi.v;
    norm_x_i <= vi.nx;
    norm_y_i <= vi.ny;
    norm_z_i <= vi.nz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_vertex(vi);
    vertices_sent++;
  endtask

  // drop valid, wait for all results and let any buffered vertex finish
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(logic signed [31:0] sx, logic signed [31:0] sy,
                              logic signed [31:0] sz, bit fu, bit fv, bit fa);
    write_cfg(CFG_SCALE_X, sx);
    write_cfg(CFG_SCALE_Y, sy);
    write_cfg(CFG_SCALE_Z, sz);
    write_cfg(CFG_FLIP_U, {31'd0, fu});
    write_cfg(CFG_FLIP_V, {31'd0, fv});
    write_cfg(CFG_FLIP_ALL, {31'd0, fa});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_applied++;
  endtask

  initial begin
    vertex_t     prev;
    int          n;
    int unsigned errors;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: field extremes and alternating bit patterns
    send_vertex(vtx(Q_MAX, Q_MIN, 0, Q_MAX, Q_MIN, N_MAX, N_MIN, 0));
    send_vertex(vtx(Q_MIN, Q_MAX, -1, 0, -1, N_MIN, N_MAX, 1));
    send_vertex(vtx(-1, 1, ONE_Q16, 32'h5555_5555, 32'haaaa_aaaa, 16'sh5555,
                    16'shaaaa, -1));
    send_vertex(vtx(32'haaaa_aaaa, 32'h5555_5555, Q_MAX, ONE_Q16, 0, 16'shaaaa,
                    16'sh5555, N_MIN));
    send_vertex(vtx(0, 0, 0, -ONE_Q16, ONE_Q16, 0, 0, 0));
    send_vertex(vtx(ONE_Q16, -ONE_Q16, ONE_Q16, 1, 32'sh0000_8000, N_UP, -N_UP, N_MAX));
    settle();

    // mirrored x, 1.5 on y, both texture flips
    apply_config(-ONE_Q16, 32'sh0001_8000, ONE_Q16, 1'b1, 1'b1, 1'b0);
    // facing away after the mirror: swapped
    send_vertex(vtx(0, 0, 0, 0, 0, 0, 0, N_UP));
    send_vertex(vtx(ONE_Q16, 0, 0, ONE_Q16, 0, 0, 0, N_UP));
    send_vertex(vtx(0, ONE_Q16, 0, 0, ONE_Q16, 0, 0, N_UP));
    // same triangle wound the other way: kept
    send_vertex(vtx(0, ONE_Q16, 0, 0, ONE_Q16, 0, 0, N_UP));
    send_vertex(vtx(ONE_Q16, 0, 0, ONE_Q16, 0, 0, 0, N_UP));
    send_vertex(vtx(0, 0, 0, 0, 0, 0, 0, N_UP));
    // flat triangle, zero dot product: swapped
    send_vertex(vtx(5, 5, 5, 7, 7, N_UP, N_UP, N_UP));
    send_vertex(vtx(5, 5, 5, 8, 8, -N_UP, N_UP, N_MAX));
    send_vertex(vtx(5, 5, 5, 9, 9, N_MIN, N_MIN, N_MIN));
    // position and texture saturation, normal negation overflow, widest check
    send_vertex(vtx(Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, N_MIN, N_MIN, N_MIN));
    send_vertex(vtx(Q_MAX, Q_MIN, Q_MAX, Q_MAX, ONE_Q16, N_MAX, N_MAX, N_MAX));
    send_vertex(vtx(-1, -1, 1, 0, -1, 0, -1, 1));
    // floor rounding of negative products
    send_vertex(vtx(-1, -1, -3, 32'sh0001_0001, -ONE_Q16, 100, -200, 300));
    send_vertex(vtx(1, 3, -65537, 32'sh7fff_0000, 32'sh8001_0000, -5, 17, N_UP));
    send_vertex(vtx(-65535, 7, 0, 2, 3, N_MAX, 0, N_MIN));
    settle();

    // extreme scales, zero scale on z, global flip
    apply_config(Q_MIN, Q_MAX, 0, 1'b0, 1'b1, 1'b1);
    send_vertex(vtx(ONE_Q16, ONE_Q16, ONE_Q16, 11, 12, N_UP, 0, 0));
    send_vertex(vtx(-ONE_Q16, 2, 3, 13, 14, 0, N_UP, 0));
    send_vertex(vtx(12345, -54321, Q_MAX, 15, 16, 0, 0, N_UP));
    settle();

    // random phases, some ending part way into a triangle
    prev = vtx(0, 0, 0, 0, 0, 0, 0, 0);
    while (vertices_sent < TOTAL_VERTICES) begin
      apply_config(rand_scale(), rand_scale(), rand_scale(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      quiet = ($urandom_range(0, 4) == 0);
      n = 3 * $urandom_range(2, 10);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        prev = rand_vertex(prev);
        send_vertex(prev);
      end
      settle();
    end

    errors = sb.n_errors + sb.pending();
    $display("summary: %0d vertices over %0d register settings, %0d results checked",
             vertices_sent, settings_applied + 1, sb.n_checked);
    $display("summary: %0d triangles emitted, %0d with first and third vertex swapped",
             sb.n_triangles, sb.n_reordered);
    if (errors == 0) begin
      $display("triangle_vertex_setup_winding_fix_tb: clean");
    end else begin
      $display("triangle_vertex_setup_winding_fix_tb: errors");
    end
    $finish;
  end

endmodule
